>>> src/tcw_pkg.sv
// shared types and codes of the text console writer
package tcw_pkg;

   // request actions
   localparam logic [1:0] ACT_PUT   = 2'd0;
   localparam logic [1:0] ACT_CLEAR = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // control characters
   localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [7:0] CHAR_TAB       = 8'd9;
   localparam logic [7:0] CHAR_NEWLINE   = 8'd10;

   localparam logic [7:0] SPACE_GLYPH = 8'h20;
   localparam logic [7:0] RESET_ATTR  = 8'h0F;

   // register indexes
   localparam int         CSR_INDEX_W = 1;
   localparam logic [0:0] CSR_FG      = 1'b0;
   localparam logic [0:0] CSR_BG      = 1'b1;
   localparam logic [3:0] FG_RESET    = 4'hF;
   localparam logic [3:0] BG_RESET    = 4'h0;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_CLEAR,
      ST_SCROLL,
      ST_READ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;       // capture the request
      logic exec;         // apply the request to cursor and screen
      logic sweep;        // write a blank at the counter address
      logic init_fill;    // sweep with the power-on blank
      logic scroll_step;  // one step of the scroll copy
      logic capture;      // take the read data as the cell word
      logic finish;       // load the response register
      logic cnt_clear;
      logic cnt_inc;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       will_scroll;
      logic       read_ok;
      logic       sweep_last;
      logic       scroll_last;
      logic       out_free;
   } status_type;

endpackage

>>> src/text_console_writer_unit.sv
// top level of the text console writer
//
// a text terminal on a COLUMNS x ROWS character-cell screen. each request on
// the req_ channel carries an action: put a character, clear the screen or
// read one cell. every request gives exactly one response on the rsp_
// channel with the cursor after the request, the cell read (zero otherwise)
// and a flag telling whether the screen scrolled up.
// the csr_ port sets the foreground and background colors of the attribute
// used by later writes, blanks, clears and scrolls.
// printable characters, newline, tab and backspace are accepted, then
// executed, then answered; a cell read adds a state that captures the
// read data. a clear sweeps the screen ram one cell a cycle; a character
// that scrolls copies the ram one cell a cycle. the single write port of
// the screen ram sets this pace; one request is in work at a time, first
// accepted, then executed. after reset the ram is filled with white-on-black
// blanks, with req_tready low; the cursor starts at the origin.
// the response register lets a new request in while the last response
// waits; a stalled receiver holds the next finished response inside.
module text_console_writer_unit #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [tcw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [3:0]                      csr_data,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // action[1:0], char_code[9:2], read_row[14:10], read_col[21:15], zero pad
   input  logic [23:0]                     req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // cursor_col[6:0], cursor_row[11:7], cursor_offset[22:12],
   // cell_word[38:23], scrolled[39]
   output logic [39:0]                     rsp_tdata
);

   import tcw_pkg::*;

   cmd_type     cmd;
   status_type  status;
   logic [6:0]  cursor_col;
   logic [4:0]  cursor_row;
   logic [10:0] cursor_offset;
   logic [15:0] cell_word;
   logic        scrolled;

   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tcw_datapath #(
      .COLUMNS   (COLUMNS),
      .ROWS      (ROWS),
      .TAB_WIDTH (TAB_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_action        (req_tdata[1:0]),
      .req_char_code     (req_tdata[9:2]),
      .req_read_row      (req_tdata[14:10]),
      .req_read_col      (req_tdata[21:15]),
      .cmd               (cmd),
      .status            (status),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_cursor_col    (cursor_col),
      .rsp_cursor_row    (cursor_row),
      .rsp_cursor_offset (cursor_offset),
      .rsp_cell_word     (cell_word),
      .rsp_scrolled      (scrolled)
   );

   assign rsp_tdata = {scrolled, cell_word, cursor_offset, cursor_row, cursor_col};

endmodule

>>> src/tcw_ram.sv
// generic single-port-write ram with registered read
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/tcw_ctrl.sv
// controller state machine of the text console writer
module tcw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  tcw_pkg::status_type status,
   output tcw_pkg::cmd_type    cmd
);

   import tcw_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      done_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      done_now   = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.sweep     = 1'b1;
            cmd.init_fill = 1'b1;
            cmd.cnt_inc   = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.cnt_clear = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            case (status.action)
               ACT_PUT: begin
                  if (status.will_scroll) begin
                     state_in = ST_SCROLL;
                  end else begin
                     done_now = 1'b1;
                  end
               end
               ACT_CLEAR: begin
                  state_in = ST_CLEAR;
               end
               ACT_READ: begin
                  if (status.read_ok) begin
                     state_in = ST_READ;
                  end else begin
                     done_now = 1'b1;
                  end
               end
               default: begin
                  done_now = 1'b1;
               end
            endcase
         end
         ST_CLEAR: begin
            cmd.sweep   = 1'b1;
            cmd.cnt_inc = 1'b1;
            done_now    = status.sweep_last;
         end
         ST_SCROLL: begin
            cmd.scroll_step = 1'b1;
            cmd.cnt_inc     = 1'b1;
            done_now        = status.scroll_last;
         end
         ST_READ: begin
            cmd.capture = 1'b1;
            done_now    = 1'b1;
         end
         ST_DONE: begin
            done_now = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // result goes out now if the response register is free, else wait
      if (done_now) begin
         if (status.out_free) begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end else begin
            state_in = ST_DONE;
         end
      end
   end

endmodule

>>> src/tcw_datapath.sv
// cursor, screen store, sweep counter and response register
module tcw_datapath #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [tcw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [3:0]                      csr_data,
   input  logic [1:0]                      req_action,
   input  logic [7:0]                      req_char_code,
   input  logic [4:0]                      req_read_row,
   input  logic [6:0]                      req_read_col,
   input  tcw_pkg::cmd_type                cmd,
   output tcw_pkg::status_type             status,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [6:0]                      rsp_cursor_col,
   output logic [4:0]                      rsp_cursor_row,
   output logic [10:0]                     rsp_cursor_offset,
   output logic [15:0]                     rsp_cell_word,
   output logic                            rsp_scrolled
);

   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CNW   = $clog2(CELLS + 1);
   localparam int CLW   = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int TPW   = $clog2(COLUMNS + TAB_WIDTH + 1);
   localparam int NSTOP = COLUMNS / TAB_WIDTH + 1;

   logic [3:0]     fg_ff, fg_in, bg_ff, bg_in;
   logic [CLW-1:0] cur_x_ff, cur_x_in;
   logic [RW-1:0]  cur_y_ff, cur_y_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic [1:0]     act_ff;
   logic [7:0]     code_ff;
   logic [4:0]     rrow_ff;
   logic [6:0]     rcol_ff;
   logic [15:0]    cell_ff, cell_in;
   logic           scr_ff, scr_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [6:0]     out_col_ff;
   logic [4:0]     out_row_ff;
   logic [10:0]    out_off_ff;
   logic [15:0]    out_cell_ff;
   logic           out_scr_ff;

   logic [15:0]    blank;
   logic [TPW-1:0] tab_stop;
   logic [CLW-1:0] put_x;
   logic [RW:0]    put_y;
   logic           put_wr;
   logic [15:0]    put_data;
   logic           put_at_new;
   logic           will_scroll;
   logic           read_ok;
   logic [RW-1:0]  addr_row;
   logic [CLW-1:0] addr_col;
   logic [AW-1:0]  lin_addr;
   logic [AW-1:0]  off_full;
   logic           wr_en, rd_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   logic [15:0]    wr_data, rd_data;

   assign blank = {bg_ff, fg_ff, SPACE_GLYPH};

   // next tab stop beyond the cursor column
   always_comb begin
      tab_stop = '0;
      for (int k = NSTOP; k >= 1; k--) begin
         if (TPW'(k * TAB_WIDTH) > TPW'(cur_x_ff)) begin
            tab_stop = TPW'(k * TAB_WIDTH);
         end
      end
   end

   // cursor motion and cell write of a put request
   always_comb begin
      put_x      = cur_x_ff;
      put_y      = {1'b0, cur_y_ff};
      put_wr     = 1'b0;
      put_data   = blank;
      put_at_new = 1'b0;
      case (code_ff)
         CHAR_NEWLINE: begin
            put_x = '0;
            put_y = put_y + 1'b1;
         end
         CHAR_BACKSPACE: begin
            put_at_new = 1'b1;
            if (cur_x_ff != '0) begin
               put_x  = cur_x_ff - 1'b1;
               put_wr = 1'b1;
            end else if (cur_y_ff != '0) begin
               put_x  = CLW'(COLUMNS - 1);
               put_y  = put_y - 1'b1;
               put_wr = 1'b1;
            end
         end
         CHAR_TAB: begin
            if (tab_stop >= TPW'(COLUMNS)) begin
               put_x = '0;
               put_y = put_y + 1'b1;
            end else begin
               put_x = CLW'(tab_stop);
            end
         end
         default: begin
            put_wr   = 1'b1;
            put_data = {bg_ff, fg_ff, code_ff};
            if (cur_x_ff == CLW'(COLUMNS - 1)) begin
               put_x = '0;
               put_y = put_y + 1'b1;
            end else begin
               put_x = cur_x_ff + 1'b1;
            end
         end
      endcase
   end

   assign will_scroll = (put_y >= (RW + 1)'(ROWS));
   assign read_ok     = (32'(rrow_ff) < ROWS) && (32'(rcol_ff) < COLUMNS);

   // one shared row times columns for writes and reads
   always_comb begin
      if (act_ff == ACT_READ) begin
         addr_row = RW'(rrow_ff);
         addr_col = CLW'(rcol_ff);
      end else if (put_at_new) begin
         addr_row = RW'(put_y);
         addr_col = put_x;
      end else begin
         addr_row = cur_y_ff;
         addr_col = cur_x_ff;
      end
   end

   assign lin_addr = AW'(AW'(addr_row) * AW'(COLUMNS) + AW'(addr_col));

   // memory port selection
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = lin_addr;
      wr_data = put_data;
      rd_en   = 1'b0;
      rd_addr = lin_addr;
      if (cmd.sweep) begin
         wr_en   = 1'b1;
         wr_addr = AW'(cnt_ff);
         wr_data = cmd.init_fill ? {RESET_ATTR, SPACE_GLYPH} : blank;
      end else if (cmd.scroll_step) begin
         // read one row ahead, write the cell read in the cycle before
         rd_en   = (cnt_ff < CNW'(CELLS - COLUMNS));
         rd_addr = AW'(cnt_ff + CNW'(COLUMNS));
         wr_en   = (cnt_ff != '0);
         wr_addr = AW'(cnt_ff - 1'b1);
         wr_data = (cnt_ff <= CNW'(CELLS - COLUMNS)) ? rd_data : blank;
      end else if (cmd.exec) begin
         wr_en = (act_ff == ACT_PUT) && put_wr;
         rd_en = (act_ff == ACT_READ) && read_ok;
      end
   end

   tcw_ram #(
      .WIDTH (16),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state of registers
   always_comb begin
      fg_in    = fg_ff;
      bg_in    = bg_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      if (csr_we) begin
         if (csr_index == CSR_FG) begin
            fg_in = csr_data;
         end
         if (csr_index == CSR_BG) begin
            bg_in = csr_data;
         end
      end
      if (cmd.exec) begin
         if (act_ff == ACT_PUT) begin
            cur_x_in = put_x;
            cur_y_in = will_scroll ? RW'(ROWS - 1) : RW'(put_y);
         end else if (act_ff == ACT_CLEAR) begin
            cur_x_in = '0;
            cur_y_in = '0;
         end
      end
      if (cmd.cnt_clear) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end else begin
         cnt_in = cnt_ff;
      end
      if (cmd.exec) begin
         cell_in = '0;
      end else if (cmd.capture) begin
         cell_in = rd_data;
      end else begin
         cell_in = cell_ff;
      end
      scr_in = cmd.exec ? ((act_ff == ACT_PUT) && will_scroll) : scr_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign off_full = AW'(AW'(cur_y_in) * AW'(COLUMNS) + AW'(cur_x_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff        <= FG_RESET;
         bg_ff        <= BG_RESET;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      scr_ff  <= scr_in;
      if (cmd.accept) begin
         act_ff  <= req_action;
         code_ff <= req_char_code;
         rrow_ff <= req_read_row;
         rcol_ff <= req_read_col;
      end
      if (cmd.finish) begin
         out_col_ff  <= 7'(cur_x_in);
         out_row_ff  <= 5'(cur_y_in);
         out_off_ff  <= 11'(off_full);
         out_cell_ff <= cell_in;
         out_scr_ff  <= scr_in;
      end
   end

   assign status.action      = act_ff;
   assign status.will_scroll = will_scroll;
   assign status.read_ok     = read_ok;
   assign status.sweep_last  = (cnt_ff == CNW'(CELLS - 1));
   assign status.scroll_last = (cnt_ff == CNW'(CELLS));
   assign status.out_free    = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_cursor_col    = out_col_ff;
   assign rsp_cursor_row    = out_row_ff;
   assign rsp_cursor_offset = out_off_ff;
   assign rsp_cell_word     = out_cell_ff;
   assign rsp_scrolled      = out_scr_ff;

endmodule
